>>> hw/rtl/thq_pkg.sv
// Shared types and constants of the touch hold qualifier.
package thq_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned TIMEOUT_W = 16;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned CHANNEL_W = 7;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] event_code;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 touched;
      logic                 last;
   } rsp_type;

endpackage

>>> hw/rtl/thq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module thq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 36
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/touch_hold_qualifier_core.sv
// Top level of the multi-channel touch press/hold qualifier.
//
// Tracks BOARDS * PINS_PER_BOARD touch channels. An event item (kind 0) with
// even code 2c marks channel c pressed and stamps it with time_ms; odd code
// 2c+1 marks it released; codes past the channel count are dropped. Events
// give no result. A tick item (kind 1) walks every channel in ascending
// order, one channel per cycle through a single 32-bit subtract and compare:
// a pressed channel is confirmed once (previous tick time - stamp), read as
// signed, exceeds hold_timeout_ms; a released channel loses confirmation.
// Each change is reported on rsp_, the final one with last set. A tick is
// accepted in idle, then scanned with the press stamps read from a RAM one
// entry per cycle, then closed by a flush state; a stalled result stream
// holds the scan and the flush. req_ready is high only between items. The
// timeout register (csr_) is always writable and resets to 10.
module touch_hold_qualifier_core #(
   parameter int unsigned BOARDS         = 3,
   parameter int unsigned PINS_PER_BOARD = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  thq_pkg::req_type              req_item,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output thq_pkg::rsp_type              rsp_item,
   // timeout register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [thq_pkg::TIMEOUT_W-1:0] csr_data
);

   localparam int unsigned NUM_CH = BOARDS * PINS_PER_BOARD;
   localparam int unsigned CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   // sequencer
   logic [1:0]                      state_ff, state_in;
   logic [CH_W-1:0]                 idx_ff, idx_in;
   // per-channel flags
   logic [NUM_CH-1:0]               raw_ff, raw_in;
   logic [NUM_CH-1:0]               conf_ff, conf_in;
   // timing
   logic [thq_pkg::TIME_W-1:0]      ref_time_ff, ref_time_in;
   logic [thq_pkg::TIME_W-1:0]      tick_time_ff, tick_time_in;
   logic [thq_pkg::TIMEOUT_W-1:0]   timeout_ff, timeout_in;
   // one report held back until we know whether another follows
   logic                            pend_valid_ff, pend_valid_in;
   thq_pkg::rsp_type                pend_ff, pend_in;
   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   thq_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            req_acc;
   logic                            ev_acc;
   logic                            ev_hit;
   logic [CH_W-1:0]                 ev_ch;
   logic [thq_pkg::TIME_W-1:0]      stamp_rd;
   logic [thq_pkg::TIME_W-1:0]      diff;
   logic                            held;
   logic                            cur_raw, cur_conf, nxt_conf, chg;
   logic                            slot_free;
   logic                            step_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // event decode: channel is code >> 1, dropped when past the channel count
   assign ev_acc = req_acc && (req_item.kind == thq_pkg::KIND_EVENT);
   assign ev_hit = ({1'b0, req_item.event_code[thq_pkg::CODE_W-1:1]}
                    < thq_pkg::CODE_W'(NUM_CH));
   assign ev_ch  = CH_W'(req_item.event_code[thq_pkg::CODE_W-1:1]);

   // stamp RAM; read address is the next scan index so data lines up with idx_ff
   thq_ram #(
      .WIDTH (thq_pkg::TIME_W),
      .DEPTH (NUM_CH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ev_acc && ev_hit && !req_item.event_code[0]),
      .wr_addr (ev_ch),
      .wr_data (req_item.time_ms),
      .rd_addr (idx_in),
      .rd_data (stamp_rd)
   );

   // the shared compare: signed elapsed time against the timeout
   assign diff     = ref_time_ff - stamp_rd;
   assign held     = !diff[thq_pkg::TIME_W-1]
                     && (diff > {{(thq_pkg::TIME_W-thq_pkg::TIMEOUT_W){1'b0}}, timeout_ff});
   assign cur_raw  = raw_ff[idx_ff];
   assign cur_conf = conf_ff[idx_ff];
   assign nxt_conf = cur_raw && (cur_conf || held);
   assign chg      = (nxt_conf != cur_conf);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   // a change with a report already pending needs the output slot
   assign step_ok   = !chg || !pend_valid_ff || slot_free;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      raw_in        = raw_ff;
      conf_in       = conf_ff;
      ref_time_in   = ref_time_ff;
      tick_time_in  = tick_time_ff;
      timeout_in    = timeout_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (ev_acc && ev_hit) begin
               raw_in[ev_ch] = !req_item.event_code[0];
            end
            if (req_acc && (req_item.kind == thq_pkg::KIND_TICK)) begin
               tick_time_in = req_item.time_ms;
               idx_in       = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ok) begin
               conf_in[idx_ff] = nxt_conf;
               if (chg) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_valid_in   = 1'b1;
                  pend_in.channel = thq_pkg::CHANNEL_W'(idx_ff);
                  pend_in.touched = nxt_conf;
                  pend_in.last    = 1'b0;
               end
               if (idx_ff == LAST_CH) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               ref_time_in = tick_time_ff;
               state_in    = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               ref_time_in   = tick_time_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         raw_ff        <= '0;
         conf_ff       <= '0;
         ref_time_ff   <= '0;
         timeout_ff    <= thq_pkg::TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         raw_ff        <= raw_in;
         conf_ff       <= conf_in;
         ref_time_ff   <= ref_time_in;
         timeout_ff    <= timeout_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_time_ff <= tick_time_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   // nothing may stay pending once the sequencer is back between items
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("report left pending in idle");

   // a new result only comes out of a tick scan or its flush
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (state_ff != ST_IDLE))
      else $error("result produced outside a tick");

   // the flush always hands out the held report marked last
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && slot_free)
      |=> (rsp_valid_ff && rsp_ff.last && state_ff == ST_IDLE))
      else $error("final report not marked last");

   // the scan index never runs past the last channel
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= LAST_CH))
      else $error("scan index out of range");

endmodule
